// ===== rtl/core/dscr_pkg.sv =====
// Shared types and constants for the five-point COO row assembler.
package dscr_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int SIDE_W     = 11;
  localparam int COORD_W    = 10;
  localparam int IDX_W      = 20;
  localparam int COEF_W     = 32;
  localparam int NUM_SLOTS  = 5;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_SIDE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROBIN_ENABLED  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DIAG_X     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DIAG_Y     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_VALUE     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_DIAG = 8'd7;

  // triplet slots in emission order, one-hot
  localparam logic [NUM_SLOTS-1:0] SLOT_X0   = 5'b00001;
  localparam logic [NUM_SLOTS-1:0] SLOT_X1   = 5'b00010;
  localparam logic [NUM_SLOTS-1:0] SLOT_Y0   = 5'b00100;
  localparam logic [NUM_SLOTS-1:0] SLOT_Y1   = 5'b01000;
  localparam logic [NUM_SLOTS-1:0] SLOT_DIAG = 5'b10000;

  typedef struct packed {
    logic [COORD_W-1:0] point_column;
    logic [COORD_W-1:0] point_row;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [COEF_W-1:0] coefficient;
    logic                     coord_error;
    logic                     last;
  } out_item_t;

  // geometry seen by the front end (sides already clamped)
  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] rows;
    logic              right;
    logic              robin;
  } geom_cfg_t;

  // values seen by the back end
  typedef struct packed {
    logic [SIDE_W-1:0]        width;
    logic signed [COEF_W-1:0] off_x;
    logic signed [COEF_W-1:0] off_y;
    logic signed [COEF_W-1:0] diag;
    logic signed [COEF_W-1:0] iface_diag;
  } coef_cfg_t;

  // classified point, one queue entry
  typedef struct packed {
    logic                 err;
    logic [IDX_W-1:0]     idx;
    logic [NUM_SLOTS-1:0] mask;
    logic                 right;
    logic                 dbl;
    logic                 iface;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/dscr_front.sv =====
// Front end: takes a point, classifies it and builds its queue entry.
module dscr_front (
  input  logic                start,
  output logic                busy,
  input  dscr_pkg::in_item_t  in_item,
  input  dscr_pkg::geom_cfg_t geom,
  input  dscr_pkg::q_status_t q_stat,
  output logic                push,
  output dscr_pkg::desc_t     push_desc
);
  import dscr_pkg::*;

  logic [SIDE_W-1:0]  col_x;
  logic [SIDE_W-1:0]  row_x;
  logic [SIDE_W-1:0]  col_p1;
  logic [SIDE_W-1:0]  row_p1;
  logic [SIDE_W-1:0]  iface_col;
  logic [IDX_W:0]     prod;
  logic               outside;
  logic               x_en;
  logic               y_en;
  logic               at_edge;
  logic               is_iface;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    col_x     = SIDE_W'(in_item.point_column);
    row_x     = SIDE_W'(in_item.point_row);
    col_p1    = col_x + SIDE_W'(1);
    row_p1    = row_x + SIDE_W'(1);
    outside   = (col_x >= geom.width) || (row_x >= geom.rows);
    iface_col = geom.right ? '0 : (geom.width - SIDE_W'(1));
    is_iface  = (col_x == iface_col);
    x_en      = col_p1 < geom.width;
    y_en      = (row_p1 < geom.rows) && !(!geom.robin && is_iface);
    at_edge   = geom.right ? (col_x == '0) : ((col_x + SIDE_W'(2)) == geom.width);
    prod      = (IDX_W+1)'(in_item.point_row) * (IDX_W+1)'(geom.width)
              + (IDX_W+1)'(in_item.point_column);

    push_desc.err   = outside;
    push_desc.idx   = IDX_W'(prod);
    push_desc.right = geom.right;
    push_desc.dbl   = at_edge;
    push_desc.iface = is_iface;
    if (outside) begin
      push_desc.mask = SLOT_DIAG;
    end else begin
      push_desc.mask = SLOT_DIAG
                     | ((x_en && (!at_edge || geom.robin)) ? SLOT_X0 : '0)
                     | (x_en ? SLOT_X1 : '0)
                     | (y_en ? (SLOT_Y0 | SLOT_Y1) : '0);
    end
  end

endmodule

// ===== rtl/core/dscr_queue.sv =====
// Short queue of classified points between the front and back ends.
module dscr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dscr_pkg::desc_t     push_desc,
  input  logic                pop,
  output dscr_pkg::desc_t     head,
  output dscr_pkg::q_status_t q_stat
);
  import dscr_pkg::*;

  desc_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r;
  logic [Q_PTR_W:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/core/dscr_back.sv =====
// Back end: walks a point's triplet slots and drives one triplet a cycle.
module dscr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dscr_pkg::coef_cfg_t coefs,
  input  dscr_pkg::desc_t     head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_strobe,
  output dscr_pkg::out_item_t out_item
);
  import dscr_pkg::*;

  desc_t                cur_r;
  desc_t                cur_nxt;
  logic                 vld_r;
  logic                 vld_nxt;
  logic [NUM_SLOTS-1:0] slot;
  logic [NUM_SLOTS-1:0] rem;
  logic                 done;
  logic [IDX_W-1:0]     idx_p1;
  logic [IDX_W-1:0]     idx_pw;
  logic signed [COEF_W-1:0] x0_coef;
  out_item_t            trip;
  logic                 strobe_r;
  out_item_t            item_r;

  function automatic logic signed [COEF_W-1:0] dbl_sat(input logic signed [COEF_W-1:0] v);
    logic signed [COEF_W-1:0] res;
    if (v[COEF_W-1] != v[COEF_W-2]) begin
      res = v[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      res = {v[COEF_W-2:0], 1'b0};
    end
    return res;
  endfunction

  always_comb begin
    slot    = cur_r.mask & (~cur_r.mask + NUM_SLOTS'(1));
    rem     = cur_r.mask & ~slot;
    done    = !vld_r || (rem == '0);
    pop     = done && !q_empty;
    idx_p1  = cur_r.idx + IDX_W'(1);
    idx_pw  = cur_r.idx + IDX_W'(coefs.width);
    x0_coef = cur_r.dbl ? dbl_sat(coefs.off_x) : coefs.off_x;

    cur_nxt = cur_r;
    vld_nxt = vld_r;
    if (done) begin
      vld_nxt = !q_empty;
      if (!q_empty) begin
        cur_nxt = head;
      end
    end else begin
      cur_nxt.mask = rem;
    end

    trip.coord_error = 1'b0;
    trip.last        = (rem == '0);
    trip.row_index   = cur_r.idx;
    trip.col_index   = cur_r.idx;
    trip.coefficient = cur_r.iface ? coefs.iface_diag : coefs.diag;
    unique case (slot)
      SLOT_X0: begin
        trip.row_index   = cur_r.right ? cur_r.idx : idx_p1;
        trip.col_index   = cur_r.right ? idx_p1 : cur_r.idx;
        trip.coefficient = x0_coef;
      end
      SLOT_X1: begin
        trip.row_index   = cur_r.right ? idx_p1 : cur_r.idx;
        trip.col_index   = cur_r.right ? cur_r.idx : idx_p1;
        trip.coefficient = coefs.off_x;
      end
      SLOT_Y0: begin
        trip.row_index   = idx_pw;
        trip.coefficient = coefs.off_y;
      end
      SLOT_Y1: begin
        trip.col_index   = idx_pw;
        trip.coefficient = coefs.off_y;
      end
      default: begin
      end
    endcase
    if (cur_r.err) begin
      trip.row_index   = '0;
      trip.col_index   = '0;
      trip.coefficient = '0;
      trip.coord_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      strobe_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    item_r <= trip;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ===== rtl/core/diffusion_subdomain_coo_rows.sv =====
// Top level of the five-point diffusion matrix COO assembler for one subdomain.
//
// Usage:
//   Input: present a grid point on in_item with start high; it is taken at a
//   rising edge where busy is low. busy rises only when the point queue is full.
//   Output: each triplet is on out_item for one cycle with out_strobe high.
//   The receiver cannot stall: triplets leave at one per cycle regardless.
//   A point gives one to five triplets (x neighbours, y neighbours, diagonal),
//   the final one flagged by last. A point outside the grid gives a single
//   zero triplet with coord_error and last set.
//   Path: when the back end is idle, a taken point goes through the queue,
//   then the back-end slot register, and its first triplet the output register.
//   Throughput: one triplet per cycle, set by the single output port of the
//   back end, which emits each point's triplets back to back; the
//   four-entry queue lets the front keep taking points meanwhile.
//   Configuration: cfg_ready is always high; write only while idle.
//   Reset (rst_n low, synchronous) empties the queue and pipeline and returns
//   the registers to width 1, rows 1, left side, Dirichlet, coefficients 0.
module diffusion_subdomain_coo_rows #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  dscr_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output dscr_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dscr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dscr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dscr_pkg::*;

  // sides above MAX_SIDE act as MAX_SIDE; beyond the register range it never bites
  localparam int SIDE_MAX_VAL = (1 << SIDE_W) - 1;
  localparam int CAP_VAL      = (MAX_SIDE > SIDE_MAX_VAL) ? SIDE_MAX_VAL : MAX_SIDE;
  localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(CAP_VAL);

  logic [SIDE_W-1:0]        grid_width_r;
  logic [SIDE_W-1:0]        grid_rows_r;
  logic                     domain_side_r;
  logic                     robin_enabled_r;
  logic signed [COEF_W-1:0] off_diag_x_r;
  logic signed [COEF_W-1:0] off_diag_y_r;
  logic signed [COEF_W-1:0] diag_value_r;
  logic signed [COEF_W-1:0] interface_diag_r;

  logic [SIDE_W-1:0] width_eff;
  logic [SIDE_W-1:0] rows_eff;
  geom_cfg_t         geom;
  coef_cfg_t         coefs;
  q_status_t         q_stat;
  desc_t             push_desc;
  desc_t             head;
  logic              push;
  logic              pop;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= SIDE_W'(1);
      grid_rows_r      <= SIDE_W'(1);
      domain_side_r    <= 1'b0;
      robin_enabled_r  <= 1'b0;
      off_diag_x_r     <= '0;
      off_diag_y_r     <= '0;
      diag_value_r     <= '0;
      interface_diag_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:     grid_width_r     <= cfg_data[SIDE_W-1:0];
        REG_GRID_ROWS:      grid_rows_r      <= cfg_data[SIDE_W-1:0];
        REG_DOMAIN_SIDE:    domain_side_r    <= cfg_data[0];
        REG_ROBIN_ENABLED:  robin_enabled_r  <= cfg_data[0];
        REG_OFF_DIAG_X:     off_diag_x_r     <= cfg_data[COEF_W-1:0];
        REG_OFF_DIAG_Y:     off_diag_y_r     <= cfg_data[COEF_W-1:0];
        REG_DIAG_VALUE:     diag_value_r     <= cfg_data[COEF_W-1:0];
        REG_INTERFACE_DIAG: interface_diag_r <= cfg_data[COEF_W-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_comb begin
    width_eff        = (grid_width_r > SIDE_CAP) ? SIDE_CAP : grid_width_r;
    rows_eff         = (grid_rows_r > SIDE_CAP) ? SIDE_CAP : grid_rows_r;
    geom.width       = width_eff;
    geom.rows        = rows_eff;
    geom.right       = domain_side_r;
    geom.robin       = robin_enabled_r;
    coefs.width      = width_eff;
    coefs.off_x      = off_diag_x_r;
    coefs.off_y      = off_diag_y_r;
    coefs.diag       = diag_value_r;
    coefs.iface_diag = interface_diag_r;
  end

  // front: take and classify points
  dscr_front u_front (
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .geom      (geom),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  // queue decouples intake from triplet emission
  dscr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: one triplet per cycle
  dscr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coefs      (coefs),
    .head       (head),
    .q_empty    (q_stat.empty),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // an out-of-grid point yields a lone zero triplet
  a_err_lone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.coord_error) |->
      (out_item.last && out_item.coefficient == '0 && out_item.row_index == '0))
    else $error("coord_error triplet not a lone zero item");

  // triplets of one point leave in consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |=> out_strobe)
    else $error("gap inside a point's triplets");

  // an accepted point is held in the queue or the back end next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !q_stat.empty)
    else $error("accepted point lost");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the five-point diffusion COO row assembler.
module testbench;
  import dscr_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int SIDE_CAP       = 1024;   // MAX_SIDE of the instance
  localparam int SETTLE_CYCLES  = 4;      // quiet cycles before registers change
  localparam int DRAIN_LIMIT    = 1000;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_POINTS   = 43;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT. Every input carries a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #HALF_PERIOD clk = ~clk;

  diffusion_subdomain_coo_rows #(
    .MAX_SIDE(SIDE_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file, starting from the reset values.
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0]        sh_width = 11'd1;
  logic [SIDE_W-1:0]        sh_rows  = 11'd1;
  logic                     sh_right = 1'b0;
  logic                     sh_robin = 1'b0;
  logic signed [COEF_W-1:0] sh_off_x = '0;
  logic signed [COEF_W-1:0] sh_off_y = '0;
  logic signed [COEF_W-1:0] sh_diag  = '0;
  logic signed [COEF_W-1:0] sh_iface = '0;

  out_item_t pending_triplets[$];   // triplets still owed by the block, oldest first
  bit        burst_mode = 1'b0;     // no gaps between points while set
  int        mismatch_count = 0;
  int        points_sent    = 0;
  int        points_outside = 0;
  int        triplets_seen  = 0;
  int        config_loads   = 0;

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_GRID_WIDTH:     sh_width = d[SIDE_W-1:0];
      REG_GRID_ROWS:      sh_rows  = d[SIDE_W-1:0];
      REG_DOMAIN_SIDE:    sh_right = d[0];
      REG_ROBIN_ENABLED:  sh_robin = d[0];
      REG_OFF_DIAG_X:     sh_off_x = d;
      REG_OFF_DIAG_Y:     sh_off_y = d;
      REG_DIAG_VALUE:     sh_diag  = d;
      REG_INTERFACE_DIAG: sh_iface = d;
      default: ;   // indexes past the last register are dropped
    endcase
  endfunction

  function automatic void push_triplet(int unsigned row, int unsigned col,
                                       logic signed [COEF_W-1:0] coef, bit err, bit fin);
    out_item_t t;
    t.row_index   = row[IDX_W-1:0];
    t.col_index   = col[IDX_W-1:0];
    t.coefficient = coef;
    t.coord_error = err;
    t.last        = fin;
    pending_triplets = {pending_triplets, t};
  endfunction

  // Works out the triplets owed for one accepted point: x couplings, y couplings,
  // then the diagonal, which closes every in-grid point; off-grid ones owe one flag.
  function automatic void predict_triplets(in_item_t pt);
    int unsigned              w, h, c, r, idx, iface_col;
    longint                   twice_x;
    logic signed [COEF_W-1:0] x_dbl;
    w = (sh_width > SIDE_CAP) ? SIDE_CAP : 32'(sh_width);
    h = (sh_rows > SIDE_CAP) ? SIDE_CAP : 32'(sh_rows);
    c = 32'(pt.point_column);
    r = 32'(pt.point_row);
    if (c >= w || r >= h) begin
      // off the grid (or an empty grid): one zeroed, flagged triplet
      points_outside++;
      push_triplet(0, 0, '0, 1'b1, 1'b1);
      return;
    end
    idx       = r * w + c;
    iface_col = sh_right ? 0 : w - 1;
    // doubled coupling saturates to the Q16.16 range
    twice_x = 2 * longint'(sh_off_x);
    if (twice_x > Q_MAX) begin
      x_dbl = 32'sh7FFF_FFFF;
    end else if (twice_x < Q_MIN) begin
      x_dbl = 32'sh8000_0000;
    end else begin
      x_dbl = twice_x[COEF_W-1:0];
    end
    if (c + 1 < w) begin
      if (!sh_right) begin
        // left side: coupling into the interface column doubled or dropped
        if (c + 2 == w) begin
          if (sh_robin) push_triplet(idx + 1, idx, x_dbl, 1'b0, 1'b0);
        end else begin
          push_triplet(idx + 1, idx, sh_off_x, 1'b0, 1'b0);
        end
        push_triplet(idx, idx + 1, sh_off_x, 1'b0, 1'b0);
      end else begin
        // right side: interface is column 0
        if (c == 0) begin
          if (sh_robin) push_triplet(idx, idx + 1, x_dbl, 1'b0, 1'b0);
        end else begin
          push_triplet(idx, idx + 1, sh_off_x, 1'b0, 1'b0);
        end
        push_triplet(idx + 1, idx, sh_off_x, 1'b0, 1'b0);
      end
    end
    // Dirichlet drops the vertical couplings on the interface column
    if (r + 1 < h && !(!sh_robin && c == iface_col)) begin
      push_triplet(idx + w, idx, sh_off_y, 1'b0, 1'b0);
      push_triplet(idx, idx + w, sh_off_y, 1'b0, 1'b0);
    end
    push_triplet(idx, idx, (c == iface_col) ? sh_iface : sh_diag, 1'b0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Result monitor: the block cannot be stalled, so every strobe is a triplet.
  // Sampled at the edge, so the values seen are those before the edge.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n && out_strobe) begin
      triplets_seen++;
      if (pending_triplets.size() == 0) begin
        $error("triplet with none owed: row %0d col %0d", out_item.row_index,
               out_item.col_index);
        mismatch_count++;
      end else begin
        want = pending_triplets.pop_front();
        check_field("row_index", longint'(want.row_index),
                    longint'(out_item.row_index));
        check_field("col_index", longint'(want.col_index),
                    longint'(out_item.col_index));
        check_field("coefficient", longint'(want.coefficient),
                    longint'(out_item.coefficient));
        check_field("coord_error", longint'(want.coord_error),
                    longint'(out_item.coord_error));
        check_field("last", longint'(want.last), longint'(out_item.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All driving is by nonblocking assignment in the step of a rising
  // edge; start stays high across back-to-back items rather than toggling.
  // ---------------------------------------------------------------------------
  task automatic send_point(in_item_t pt);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= pt;
    do @(posedge clk); while (busy);
    predict_triplets(pt);
    points_sent++;
  endtask

  task automatic send_at(int unsigned col, int unsigned row);
    in_item_t pt;
    pt.point_column = col[COORD_W-1:0];
    pt.point_row    = row[COORD_W-1:0];
    send_point(pt);
  endtask

  // Drop start, wait for every owed triplet, then a short pause so the
  // block is quiet before registers change.
  task automatic settle();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_triplets.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] w_word, logic [31:0] h_word, bit side, bit robin,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] dg,
                             logic [31:0] ifd);
    write_reg(REG_GRID_WIDTH, w_word);
    write_reg(REG_GRID_ROWS, h_word);
    write_reg(REG_DOMAIN_SIDE, {31'b0, side});
    write_reg(REG_ROBIN_ENABLED, {31'b0, robin});
    write_reg(REG_OFF_DIAG_X, ox);
    write_reg(REG_OFF_DIAG_Y, oy);
    write_reg(REG_DIAG_VALUE, dg);
    write_reg(REG_INTERFACE_DIAG, ifd);
    config_loads++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset state is a 1x1 left Dirichlet grid with zero coefficients.
  task automatic test_reset_defaults();
    send_at(0, 0);
    send_at(1, 0);
    send_at(0, 1);
    send_at(1023, 1023);
    settle();
  endtask

  // 4x3 left grid, Dirichlet: dropped coupling at W-2, interface diagonal,
  // no y couplings on the last row or the interface column, off-grid points.
  task automatic test_left_dirichlet();
    load_config(4, 3, 1'b0, 1'b0, 32'h0001_0000, 32'h0000_8000, 32'hFFFC_0000,
                32'h0003_0000);
    send_at(0, 0);
    send_at(2, 1);
    send_at(3, 0);
    send_at(1, 2);
    send_at(3, 2);
    send_at(4, 0);
    send_at(0, 3);
    settle();
  endtask

  // Robin doubling at both saturation limits.
  task automatic test_robin_saturation();
    load_config(4, 2, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h1234_5678, 32'h0004_0000,
                32'h0005_0000);
    send_at(2, 0);
    send_at(3, 0);
    settle();
    load_config(4, 2, 1'b0, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF);
    send_at(2, 1);
    settle();
  endtask

  // Right side: interface on column 0, Dirichlet then Robin, then one column.
  task automatic test_right_side();
    load_config(5, 3, 1'b1, 1'b0, 32'h0002_0000, 32'h0000_4000, 32'h0001_8000,
                32'hFFFF_0000);
    send_at(0, 0);
    send_at(1, 1);
    send_at(4, 2);
    settle();
    load_config(5, 3, 1'b1, 1'b1, 32'hC000_0000, 32'h0000_4000, 32'h0001_8000,
                32'hFFFF_0000);
    send_at(0, 1);
    send_at(3, 0);
    settle();
    // single column: column 0 is the interface and takes its diagonal
    load_config(1, 2, 1'b1, 1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                32'h0006_0000);
    send_at(0, 0);
    settle();
  endtask

  // Sides beyond the cap act as the cap; writes past the last register are
  // ignored; a zero-width grid flags every point.
  task automatic test_oversized_grid();
    load_config(2047, 2047, 1'b0, 1'b1, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0003,
                32'h0000_0005);
    send_at(1023, 1023);
    send_at(1022, 0);
    send_at(0, 1022);
    settle();
    write_reg(8'hFF, 32'hFFFF_FFFF);
    write_reg(8'd8, 32'h0000_0000);
    load_config(0, 5, 1'b0, 1'b0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                32'h0000_0004);
    send_at(0, 0);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Random test: each phase loads a fresh configuration, then mostly in-grid
  // points biased toward the edges and the interface, plus some strays.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_side();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return SIDE_CAP;
      2:       return $urandom_range(SIDE_CAP + 1, 2047);
      3:       return $urandom_range(1, 2047);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h4000_0000;   // doubling just overflows
      3:       return 32'hBFFF_FFFF;   // doubling just underflows
      4:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_coord(int unsigned span);
    if (span == 0) return $urandom_range(0, 1023);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return span - 1;
      2:       return (span >= 2) ? span - 2 : 0;
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  task automatic test_random_points();
    int unsigned w, h, ew, eh, c, r;
    logic [31:0] w_word, h_word;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      w = pick_side();
      h = pick_side();
      w_word = w;
      h_word = h;
      // upper data bits of the size registers are junk the block must ignore
      if ($urandom_range(0, 1)) begin
        w_word[31:SIDE_W] = (32-SIDE_W)'($urandom);
        h_word[31:SIDE_W] = (32-SIDE_W)'($urandom);
      end
      load_config(w_word, h_word, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  pick_coef(), pick_coef(), pick_coef(), pick_coef());
      ew = (w > SIDE_CAP) ? SIDE_CAP : w;
      eh = (h > SIDE_CAP) ? SIDE_CAP : h;
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_POINTS; k++) begin
        case ($urandom_range(0, 9))
          0: begin   // anything the fields allow
            c = $urandom_range(0, 1023);
            r = $urandom_range(0, 1023);
          end
          1: begin   // just off the right or bottom edge
            c = (ew < SIDE_CAP) ? ew : $urandom_range(0, 1023);
            r = (eh < SIDE_CAP && $urandom_range(0, 1)) ? eh : pick_coord(eh);
          end
          default: begin
            c = pick_coord(ew);
            r = pick_coord(eh);
          end
        endcase
        send_at(c, r);
      end
      settle();
    end
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_left_dirichlet();
    test_robin_saturation();
    test_right_side();
    test_oversized_grid();
    test_random_points();
    if (pending_triplets.size() != 0) begin
      $error("%0d triplets never arrived", pending_triplets.size());
      mismatch_count++;
    end
    $display("Covered %0d points (%0d off the grid), %0d triplets checked,",
             points_sent, points_outside, triplets_seen);
    $display("over %0d register loads on both sides, Robin and Dirichlet.", config_loads);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
